>>> rtl/qfa_pkg.sv
// ----------------------------------------------------------------------------
// qfa_pkg
// Types, opcodes and constants shared by the Q16.16 arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package qfa_pkg;

    typedef struct packed {
        logic [4:0]         opcode;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
        logic signed [31:0] operand_c;
    } in_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic               compare_true;
    } out_t;

    localparam logic [4:0] OP_ADD      = 5'd0;
    localparam logic [4:0] OP_SUB      = 5'd1;
    localparam logic [4:0] OP_MUL      = 5'd2;
    localparam logic [4:0] OP_DIV      = 5'd3;
    localparam logic [4:0] OP_NEG      = 5'd4;
    localparam logic [4:0] OP_ABS      = 5'd5;
    localparam logic [4:0] OP_EQ       = 5'd6;
    localparam logic [4:0] OP_LT       = 5'd7;
    localparam logic [4:0] OP_LE       = 5'd8;
    localparam logic [4:0] OP_GT       = 5'd9;
    localparam logic [4:0] OP_GE       = 5'd10;
    localparam logic [4:0] OP_FROM_INT = 5'd11;
    localparam logic [4:0] OP_TO_INT   = 5'd12;
    localparam logic [4:0] OP_TO_INT_R = 5'd13;
    localparam logic [4:0] OP_SQRT     = 5'd14;
    localparam logic [4:0] OP_RECIP    = 5'd15;
    localparam logic [4:0] OP_FLOOR    = 5'd16;
    localparam logic [4:0] OP_CEIL     = 5'd17;
    localparam logic [4:0] OP_ROUND    = 5'd18;
    localparam logic [4:0] OP_MIN      = 5'd19;
    localparam logic [4:0] OP_MAX      = 5'd20;
    localparam logic [4:0] OP_CLAMP    = 5'd21;
    localparam logic [4:0] OP_LERP     = 5'd22;
    localparam logic [4:0] OP_SIN      = 5'd23;
    localparam logic [4:0] OP_COS      = 5'd24;
    localparam logic [4:0] OP_TAN      = 5'd25;

    localparam logic [31:0] Q_ONE     = 32'h0001_0000;
    localparam logic [31:0] Q_HALF    = 32'h0000_8000;
    localparam logic [31:0] Q_TWO     = 32'h0002_0000;
    localparam logic [31:0] Q_PI      = 32'h0003_243F;
    localparam logic [31:0] Q_TWO_PI  = 32'h0006_487E;
    localparam logic [31:0] Q_HALF_PI = 32'h0001_921F;
    localparam logic [31:0] Q_ERRMAX  = 32'h7FFF_FFFF;
    // floor(2^50 / Q_TWO_PI); the quotient estimate is low by at most one
    localparam logic [31:0] Q_TWO_PI_RCP = 32'd2734266628;
    // Taylor coefficients 1/6, 1/120, 1/5040 as truncated Q16.16
    localparam logic [31:0] Q_C3      = 32'd10922;
    localparam logic [31:0] Q_C5      = 32'd546;
    localparam logic [31:0] Q_C7      = 32'd13;

    localparam logic [2:0] SER_LAST = 3'd6;

    typedef enum logic [3:0] {
        MP_AB, MP_LERP, MP_RC1, MP_RC2, MP_XX, MP_P2X, MP_P3P2, MP_P5P2,
        MP_P3C3, MP_P5C5, MP_P7C7
    } msel_t;

    typedef enum logic [1:0] {
        DS_AB, DS_SQ, DS_MOD, DS_TAN
    } dsel_t;

    typedef enum logic [4:0] {
        WR_NONE, WR_SIMPLE, WR_RES_MUL, WR_RES_LERP, WR_RES_DIV, WR_RES_ZERO,
        WR_RES_ERR, WR_SQ_INIT, WR_SQ_STEP, WR_RC_INIT, WR_T, WR_RC_STEP,
        WR_X_SIN, WR_X_COS, WR_X_FIX, WR_SERIES, WR_SIN, WR_RES_ACC
    } wr_t;

    typedef struct packed {
        logic       load;
        logic       out_load;
        logic       mul_go;
        msel_t      mul_sel;
        logic       div_go;
        dsel_t      div_sel;
        wr_t        wr;
        logic [2:0] k;
    } cmd_t;

    typedef struct packed {
        logic [4:0] opcode;
        logic       a_neg;
        logic       a_zero;
        logic       div_done;
        logic       sq_conv;
        logic       rc_conv;
        logic       tr_out;
    } stat_t;

endpackage

`default_nettype wire

>>> rtl/qfa_div.sv
// ----------------------------------------------------------------------------
// qfa_div
// Restoring unsigned divider, 48-bit dividend by 32-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module qfa_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [47:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [47:0]      quo
);

    logic [47:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] rs;
    logic [32:0] diff;

    always_comb begin
        rs   = {r_reg, q_reg[47]};
        diff = rs - {1'b0, d_reg};
        if (!diff[32]) begin
            r_next = diff[31:0];
            q_next = {q_reg[46:0], 1'b1};
        end else begin
            r_next = rs[31:0];
            q_next = {q_reg[46:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == 6'd47);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd47) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end else if (busy_reg) begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

`default_nettype wire

>>> rtl/qfa_datapath.sv
// ----------------------------------------------------------------------------
// qfa_datapath
// Operand and working registers, shared multiplier, divider and result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module qfa_datapath (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire qfa_pkg::in_t   in_data,
    input  wire qfa_pkg::cmd_t  cmd,
    output qfa_pkg::stat_t      stat,
    output qfa_pkg::out_t       out_data
);

    logic [4:0]  op_reg;
    logic [31:0] a_reg, b_reg, c_reg;
    logic [31:0] g_reg, t_reg, x_reg;
    logic [31:0] p2_reg, p3_reg, p5_reg, p7_reg;
    logic [31:0] acc_reg, sin_reg, res_reg;
    logic        flag_reg;
    logic [63:0] prod_reg;
    logic        mneg_reg, dneg_reg, dzero_reg;
    qfa_pkg::out_t out_reg;

    logic [31:0] mx, my, mul_res, m_mag;
    logic [31:0] dn, dv, div_res, q_mag;
    logic [47:0] dividend;
    logic [31:0] divisor;
    logic        div_done;
    logic [47:0] quo;
    logic        div_start, mod_start;

    logic [63:0] mprod_reg;
    logic [31:0] md_reg, mr0_reg, mrem_reg;
    logic        mv1_reg, mv2_reg, mod_done_reg;
    logic [33:0] mq_prod;

    logic [31:0] simple_res;
    logic        simple_flag;
    logic [31:0] sq_s, sq_nx, rc_init, ax, tr_d, tr_fix, sq_init;
    logic        tr_hi, tr_lo;

    function automatic logic [31:0] mag(input logic [31:0] v);
        mag = v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic lt(input logic [31:0] p, input logic [31:0] q);
        lt = $signed(p) < $signed(q);
    endfunction

    // multiplier operand select
    always_comb begin
        unique case (cmd.mul_sel)
            qfa_pkg::MP_AB:   begin mx = a_reg;         my = b_reg;       end
            qfa_pkg::MP_LERP: begin mx = b_reg - a_reg; my = c_reg;       end
            qfa_pkg::MP_RC1:  begin mx = a_reg;         my = g_reg;       end
            qfa_pkg::MP_RC2:  begin mx = g_reg;         my = t_reg;       end
            qfa_pkg::MP_XX:   begin mx = x_reg;         my = x_reg;       end
            qfa_pkg::MP_P2X:  begin mx = p2_reg;        my = x_reg;       end
            qfa_pkg::MP_P3P2: begin mx = p3_reg;        my = p2_reg;      end
            qfa_pkg::MP_P5P2: begin mx = p5_reg;        my = p2_reg;      end
            qfa_pkg::MP_P3C3: begin mx = p3_reg;        my = qfa_pkg::Q_C3; end
            qfa_pkg::MP_P5C5: begin mx = p5_reg;        my = qfa_pkg::Q_C5; end
            qfa_pkg::MP_P7C7: begin mx = p7_reg;        my = qfa_pkg::Q_C7; end
            default:          begin mx = a_reg;         my = b_reg;       end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_go) begin
            prod_reg <= {32'd0, mag(mx)} * {32'd0, mag(my)};
            mneg_reg <= mx[31] ^ my[31];
        end
    end

    assign m_mag   = prod_reg[47:16];
    assign mul_res = mneg_reg ? (~m_mag + 32'd1) : m_mag;

    // sine argument range check and reduction
    assign tr_hi  = lt(qfa_pkg::Q_PI, x_reg);
    assign tr_lo  = lt(x_reg, ~qfa_pkg::Q_PI + 32'd1);
    assign tr_d   = tr_hi ? (x_reg - qfa_pkg::Q_PI) : ((~qfa_pkg::Q_PI + 32'd1) - x_reg);

    always_comb begin
        if (tr_hi) begin
            tr_fix = (mrem_reg == 32'd0) ? qfa_pkg::Q_PI : (mrem_reg - qfa_pkg::Q_PI);
        end else begin
            tr_fix = (mrem_reg == 32'd0) ? (~qfa_pkg::Q_PI + 32'd1)
                                         : (qfa_pkg::Q_PI - mrem_reg);
        end
    end

    // remainder by two pi: reciprocal multiply, back-multiply, one correction
    assign mod_start = cmd.div_go && (cmd.div_sel == qfa_pkg::DS_MOD);
    assign div_start = cmd.div_go && (cmd.div_sel != qfa_pkg::DS_MOD);
    assign mq_prod   = {20'd0, mprod_reg[63:50]} * {2'd0, qfa_pkg::Q_TWO_PI};

    always_ff @(posedge aclk) begin
        if (mod_start) begin
            mprod_reg <= {32'd0, tr_d} * {32'd0, qfa_pkg::Q_TWO_PI_RCP};
            md_reg    <= tr_d;
        end
        if (mv1_reg) begin
            mr0_reg <= md_reg - mq_prod[31:0];
        end
        if (mv2_reg) begin
            mrem_reg <= (mr0_reg >= qfa_pkg::Q_TWO_PI) ? (mr0_reg - qfa_pkg::Q_TWO_PI)
                                                       : mr0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv1_reg      <= 1'b0;
            mv2_reg      <= 1'b0;
            mod_done_reg <= 1'b0;
        end else begin
            mv1_reg      <= mod_start;
            mv2_reg      <= mv1_reg;
            mod_done_reg <= mv2_reg;
        end
    end

    // divider operand select
    always_comb begin
        unique case (cmd.div_sel)
            qfa_pkg::DS_AB:  begin dn = a_reg;   dv = b_reg;   end
            qfa_pkg::DS_SQ:  begin dn = a_reg;   dv = g_reg;   end
            qfa_pkg::DS_TAN: begin dn = sin_reg; dv = acc_reg; end
            default:         begin dn = a_reg;   dv = b_reg;   end
        endcase
        dividend = {mag(dn), 16'd0};
        divisor  = mag(dv);
    end

    always_ff @(posedge aclk) begin
        if (div_start) begin
            dneg_reg  <= dn[31] ^ dv[31];
            dzero_reg <= (dv == 32'd0);
        end
    end

    qfa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quo      (quo)
    );

    assign q_mag   = quo[31:0];
    assign div_res = dzero_reg ? qfa_pkg::Q_ERRMAX : (dneg_reg ? (~q_mag + 32'd1) : q_mag);

    // Newton step values
    assign sq_s    = g_reg + div_res;
    assign sq_nx   = {sq_s[31], sq_s[31:1]};
    assign sq_init = (a_reg >= qfa_pkg::Q_ONE) ? {1'b0, a_reg[31:1]} : qfa_pkg::Q_HALF;
    assign ax      = mag(a_reg);

    always_comb begin
        if (ax[31:16] >= 16'h8000) begin
            rc_init = qfa_pkg::Q_TWO;
        end else if (ax[31:16] >= 16'd2) begin
            rc_init = qfa_pkg::Q_HALF;
        end else if (ax[31:16] >= 16'd1) begin
            rc_init = qfa_pkg::Q_ONE;
        end else begin
            rc_init = qfa_pkg::Q_TWO;
        end
    end

    // combinational results of the simple opcodes
    always_comb begin
        simple_flag = 1'b0;
        simple_res  = '0;
        unique case (op_reg)
            qfa_pkg::OP_ADD: simple_res = a_reg + b_reg;
            qfa_pkg::OP_SUB: simple_res = a_reg - b_reg;
            qfa_pkg::OP_NEG: simple_res = ~a_reg + 32'd1;
            qfa_pkg::OP_ABS: simple_res = ax;
            qfa_pkg::OP_EQ:  simple_flag = (a_reg == b_reg);
            qfa_pkg::OP_LT:  simple_flag = lt(a_reg, b_reg);
            qfa_pkg::OP_LE:  simple_flag = !lt(b_reg, a_reg);
            qfa_pkg::OP_GT:  simple_flag = lt(b_reg, a_reg);
            qfa_pkg::OP_GE:  simple_flag = !lt(a_reg, b_reg);
            qfa_pkg::OP_FROM_INT: simple_res = {a_reg[15:0], 16'd0};
            qfa_pkg::OP_TO_INT:   simple_res = {{16{a_reg[31]}}, a_reg[31:16]};
            qfa_pkg::OP_TO_INT_R:
                simple_res = {{16{a_reg[31]}}, a_reg[31:16]} + {31'd0, a_reg[15]};
            qfa_pkg::OP_FLOOR: simple_res = {a_reg[31:16], 16'd0};
            qfa_pkg::OP_CEIL:
                simple_res = {a_reg[31:16], 16'd0}
                           + ((a_reg[15:0] != 16'd0) ? qfa_pkg::Q_ONE : 32'd0);
            qfa_pkg::OP_ROUND:
                simple_res = {a_reg[31:16], 16'd0} + (a_reg[15] ? qfa_pkg::Q_ONE : 32'd0);
            qfa_pkg::OP_MIN: simple_res = lt(a_reg, b_reg) ? a_reg : b_reg;
            qfa_pkg::OP_MAX: simple_res = lt(b_reg, a_reg) ? a_reg : b_reg;
            qfa_pkg::OP_CLAMP:
                simple_res = lt(a_reg, b_reg) ? b_reg : (lt(c_reg, a_reg) ? c_reg : a_reg);
            default: simple_res = '0;
        endcase
        if (simple_flag) begin
            simple_res = 32'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= in_data.opcode;
            a_reg    <= in_data.operand_a;
            b_reg    <= in_data.operand_b;
            c_reg    <= in_data.operand_c;
            flag_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            out_reg.result       <= res_reg;
            out_reg.compare_true <= flag_reg;
        end
        unique case (cmd.wr)
            qfa_pkg::WR_SIMPLE: begin
                res_reg  <= simple_res;
                flag_reg <= simple_flag;
            end
            qfa_pkg::WR_RES_MUL:  res_reg <= mul_res;
            qfa_pkg::WR_RES_LERP: res_reg <= a_reg + mul_res;
            qfa_pkg::WR_RES_DIV:  res_reg <= div_res;
            qfa_pkg::WR_RES_ZERO: res_reg <= '0;
            qfa_pkg::WR_RES_ERR:  res_reg <= qfa_pkg::Q_ERRMAX;
            qfa_pkg::WR_SQ_INIT:  g_reg   <= sq_init;
            qfa_pkg::WR_SQ_STEP: begin
                g_reg   <= sq_nx;
                res_reg <= sq_nx;
            end
            qfa_pkg::WR_RC_INIT:  g_reg <= rc_init;
            qfa_pkg::WR_T:        t_reg <= qfa_pkg::Q_TWO - mul_res;
            qfa_pkg::WR_RC_STEP: begin
                g_reg   <= mul_res;
                res_reg <= mul_res;
            end
            qfa_pkg::WR_X_SIN: x_reg <= a_reg;
            qfa_pkg::WR_X_COS: x_reg <= a_reg + qfa_pkg::Q_HALF_PI;
            qfa_pkg::WR_X_FIX: x_reg <= tr_fix;
            qfa_pkg::WR_SERIES: begin
                unique case (cmd.k)
                    3'd0:    p2_reg  <= mul_res;
                    3'd1:    p3_reg  <= mul_res;
                    3'd2:    p5_reg  <= mul_res;
                    3'd3:    p7_reg  <= mul_res;
                    3'd4:    acc_reg <= x_reg - mul_res;
                    3'd5:    acc_reg <= acc_reg + mul_res;
                    default: acc_reg <= acc_reg - mul_res;
                endcase
            end
            qfa_pkg::WR_SIN:     sin_reg <= acc_reg;
            qfa_pkg::WR_RES_ACC: res_reg <= acc_reg;
            default: ;
        endcase
    end

    always_comb begin
        stat.opcode   = op_reg;
        stat.a_neg    = a_reg[31];
        stat.a_zero   = (a_reg == 32'd0);
        stat.div_done = div_done || mod_done_reg;
        stat.sq_conv  = (sq_nx == g_reg);
        stat.rc_conv  = (mul_res == g_reg);
        stat.tr_out   = tr_hi || tr_lo;
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

>>> rtl/qfa_ctrl.sv
// ----------------------------------------------------------------------------
// qfa_ctrl
// Sequencer: steps each opcode through the shared multiplier and divider where it needs them.
// ----------------------------------------------------------------------------
`default_nettype none

module qfa_ctrl #(
    parameter int NEWTON_STEPS = 8
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  wire logic           m_ready,
    input  wire qfa_pkg::stat_t stat,
    output qfa_pkg::cmd_t       cmd
);

    localparam int CW = (NEWTON_STEPS > 1) ? $clog2(NEWTON_STEPS) : 1;
    localparam logic [CW-1:0] CNT_LAST = CW'(NEWTON_STEPS - 1);

    typedef enum logic [19:0] {
        ST_IDLE     = 20'h00001,
        ST_DISPATCH = 20'h00002,
        ST_MUL_GO   = 20'h00004,
        ST_MUL_WR   = 20'h00008,
        ST_DIV_GO   = 20'h00010,
        ST_DIV_WAIT = 20'h00020,
        ST_SQ_INIT  = 20'h00040,
        ST_SQ_DIV   = 20'h00080,
        ST_SQ_WAIT  = 20'h00100,
        ST_RC_INIT  = 20'h00200,
        ST_RC_M1    = 20'h00400,
        ST_RC_T     = 20'h00800,
        ST_RC_M2    = 20'h01000,
        ST_RC_STEP  = 20'h02000,
        ST_TR_ARG   = 20'h04000,
        ST_TR_CHK   = 20'h08000,
        ST_TR_MWAIT = 20'h10000,
        ST_TR_MUL   = 20'h20000,
        ST_TR_WR    = 20'h40000,
        ST_TR_END   = 20'h80000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [2:0]    k_reg, k_next;
    logic          pass_reg, pass_next;
    logic          m_valid_reg, m_valid_next;
    logic          done_reg, done_next;
    logic          out_free;
    logic          is_tan;

    assign out_free = !m_valid_reg || m_ready;
    assign is_tan   = (stat.opcode == qfa_pkg::OP_TAN);

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        pass_next    = pass_reg;
        done_next    = done_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '{load: 1'b0, out_load: 1'b0, mul_go: 1'b0,
                         mul_sel: qfa_pkg::MP_AB, div_go: 1'b0,
                         div_sel: qfa_pkg::DS_AB, wr: qfa_pkg::WR_NONE, k: k_reg};
        s_ready      = 1'b0;

        // finished result waits here for the output register
        if (done_reg && out_free) begin
            cmd.out_load = 1'b1;
            m_valid_next = 1'b1;
            done_next    = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = !done_reg;
                if (s_valid && !done_reg) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (stat.opcode)
                    qfa_pkg::OP_MUL, qfa_pkg::OP_LERP: state_next = ST_MUL_GO;
                    qfa_pkg::OP_DIV: state_next = ST_DIV_GO;
                    qfa_pkg::OP_SQRT: begin
                        if (stat.a_neg || stat.a_zero) begin
                            cmd.wr     = qfa_pkg::WR_RES_ZERO;
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end else begin
                            state_next = ST_SQ_INIT;
                        end
                    end
                    qfa_pkg::OP_RECIP: begin
                        if (stat.a_zero) begin
                            cmd.wr     = qfa_pkg::WR_RES_ERR;
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end else begin
                            state_next = ST_RC_INIT;
                        end
                    end
                    qfa_pkg::OP_SIN, qfa_pkg::OP_COS, qfa_pkg::OP_TAN: begin
                        pass_next  = 1'b0;
                        state_next = ST_TR_ARG;
                    end
                    default: begin
                        cmd.wr     = qfa_pkg::WR_SIMPLE;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_MUL_GO: begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = (stat.opcode == qfa_pkg::OP_LERP) ? qfa_pkg::MP_LERP
                                                                 : qfa_pkg::MP_AB;
                state_next  = ST_MUL_WR;
            end
            ST_MUL_WR: begin
                cmd.wr     = (stat.opcode == qfa_pkg::OP_LERP) ? qfa_pkg::WR_RES_LERP
                                                                : qfa_pkg::WR_RES_MUL;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_DIV_GO: begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = qfa_pkg::DS_AB;
                state_next  = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (stat.div_done) begin
                    cmd.wr     = qfa_pkg::WR_RES_DIV;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SQ_INIT: begin
                cmd.wr     = qfa_pkg::WR_SQ_INIT;
                cnt_next   = '0;
                state_next = ST_SQ_DIV;
            end
            ST_SQ_DIV: begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = qfa_pkg::DS_SQ;
                state_next  = ST_SQ_WAIT;
            end
            ST_SQ_WAIT: begin
                if (stat.div_done) begin
                    cmd.wr = qfa_pkg::WR_SQ_STEP;
                    if (stat.sq_conv || cnt_reg == CNT_LAST) begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        cnt_next   = cnt_reg + CW'(1);
                        state_next = ST_SQ_DIV;
                    end
                end
            end
            ST_RC_INIT: begin
                cmd.wr     = qfa_pkg::WR_RC_INIT;
                cnt_next   = '0;
                state_next = ST_RC_M1;
            end
            ST_RC_M1: begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = qfa_pkg::MP_RC1;
                state_next  = ST_RC_T;
            end
            ST_RC_T: begin
                cmd.wr     = qfa_pkg::WR_T;
                state_next = ST_RC_M2;
            end
            ST_RC_M2: begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = qfa_pkg::MP_RC2;
                state_next  = ST_RC_STEP;
            end
            ST_RC_STEP: begin
                cmd.wr = qfa_pkg::WR_RC_STEP;
                if (stat.rc_conv || cnt_reg == CNT_LAST) begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = ST_RC_M1;
                end
            end
            ST_TR_ARG: begin
                cmd.wr     = (pass_reg || stat.opcode == qfa_pkg::OP_COS) ? qfa_pkg::WR_X_COS
                                                                         : qfa_pkg::WR_X_SIN;
                state_next = ST_TR_CHK;
            end
            ST_TR_CHK: begin
                k_next = '0;
                if (stat.tr_out) begin
                    cmd.div_go  = 1'b1;
                    cmd.div_sel = qfa_pkg::DS_MOD;
                    state_next  = ST_TR_MWAIT;
                end else begin
                    state_next  = ST_TR_MUL;
                end
            end
            ST_TR_MWAIT: begin
                if (stat.div_done) begin
                    cmd.wr     = qfa_pkg::WR_X_FIX;
                    state_next = ST_TR_MUL;
                end
            end
            ST_TR_MUL: begin
                cmd.mul_go = 1'b1;
                unique case (k_reg)
                    3'd0:    cmd.mul_sel = qfa_pkg::MP_XX;
                    3'd1:    cmd.mul_sel = qfa_pkg::MP_P2X;
                    3'd2:    cmd.mul_sel = qfa_pkg::MP_P3P2;
                    3'd3:    cmd.mul_sel = qfa_pkg::MP_P5P2;
                    3'd4:    cmd.mul_sel = qfa_pkg::MP_P3C3;
                    3'd5:    cmd.mul_sel = qfa_pkg::MP_P5C5;
                    default: cmd.mul_sel = qfa_pkg::MP_P7C7;
                endcase
                state_next = ST_TR_WR;
            end
            ST_TR_WR: begin
                cmd.wr = qfa_pkg::WR_SERIES;
                if (k_reg == qfa_pkg::SER_LAST) begin
                    state_next = ST_TR_END;
                end else begin
                    k_next     = k_reg + 3'd1;
                    state_next = ST_TR_MUL;
                end
            end
            ST_TR_END: begin
                if (is_tan && !pass_reg) begin
                    cmd.wr     = qfa_pkg::WR_SIN;
                    pass_next  = 1'b1;
                    state_next = ST_TR_ARG;
                end else if (is_tan) begin
                    cmd.div_go  = 1'b1;
                    cmd.div_sel = qfa_pkg::DS_TAN;
                    state_next  = ST_DIV_WAIT;
                end else begin
                    cmd.wr     = qfa_pkg::WR_RES_ACC;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            k_reg       <= '0;
            pass_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            k_reg       <= k_next;
            pass_reg    <= pass_next;
            m_valid_reg <= m_valid_next;
            done_reg    <= done_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

>>> rtl/q16_16_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// q16_16_fixed_point_alu
// Signed Q16.16 arithmetic unit with a sequencer, one shared multiplier and
// one iterative divider.
// ----------------------------------------------------------------------------
// One item is worked at a time; the output register frees the unit to take
// the next item while a result still waits. The divider retires one quotient
// bit per cycle over 48 bits. Sqrt and reciprocal take at most NEWTON_STEPS
// Newton steps each. Sin and cos reduce the argument by a reciprocal multiply
// when it lies outside [-pi, pi]; tan runs both and a divide.
`default_nettype none

module q16_16_fixed_point_alu #(
    parameter int NEWTON_STEPS = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire qfa_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output qfa_pkg::out_t      m_data
);

    qfa_pkg::cmd_t  cmd;
    qfa_pkg::stat_t stat;

    qfa_ctrl #(
        .NEWTON_STEPS (NEWTON_STEPS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    qfa_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_data  (s_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (m_data)
    );

endmodule

`default_nettype wire
